// ----- rtl/nllfr_pkg.sv -----
// Shared constants, codes and control types for the NLL loss forward block.
package nllfr_pkg;

  // Problem size
  localparam int NUM_CLASSES  = 1024;
  localparam int TABLE_DEPTH  = 1024;
  localparam int TABLE_AW     = $clog2(TABLE_DEPTH);

  // Field widths
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int MODE_W       = 2;
  localparam int SLOT_W       = 10;
  localparam int WGT_W        = 16;
  localparam int TGT_W        = 16;
  localparam int X_W          = 24;
  localparam int LOSS_W       = 48;
  localparam int WACC_W       = 26;

  // Fixed-point arithmetic
  localparam int FRAC_SHIFT   = 12;
  localparam int WEIGHT_ONE   = 1 << FRAC_SHIFT;
  localparam int ROUND_HALF   = 1 << (FRAC_SHIFT - 1);
  localparam int WSEL_W       = WGT_W + 1;
  localparam int PROD_W       = X_W + WSEL_W + 1;
  localparam int TERM_W       = 30;
  localparam int NUM_W        = LOSS_W + FRAC_SHIFT;
  localparam int CNT_W        = $clog2(NUM_W);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_USEW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_IGNORE = 2'd2;

  // Reduction modes (sum and the unused code both reduce by plain sum)
  localparam logic [MODE_W-1:0] RED_NONE = 2'd0;
  localparam logic [MODE_W-1:0] RED_MEAN = 2'd1;

  // Request types
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Reset values of the configuration registers
  localparam logic [MODE_W-1:0] MODE_RST   = RED_MEAN;
  localparam logic              USEW_RST   = 1'b0;
  localparam logic [TGT_W-1:0]  IGNORE_RST = 16'hFF9C;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_TERM,
    S_ACC,
    S_CHK,
    S_DLOAD,
    S_DIV,
    S_FIN,
    S_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic wr_entry;
    logic capture;
    logic mul_en;
    logic term_en;
    logic acc_en;
    logic chk_en;
    logic dload_en;
    logic div_step;
    logic fin_en;
    logic res_term;
    logic res_acc;
    logic out_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic mode_none;
    logic mode_mean;
    logic last;
    logic wacc_zero;
  } dp_stat_t;

endpackage

// ----- rtl/nllfr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module nllfr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/nllfr_ctrl.sv -----
// Sequencing state machine: item acceptance, divider stepping and result hand-off.
module nllfr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_req_type,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  nllfr_pkg::dp_stat_t   stat,
  output nllfr_pkg::ctrl_cmd_t  cmd
);
  import nllfr_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  // State, divider count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_req_type == REQ_SAMPLE) begin
            cmd.capture = 1'b1;
            state_nxt   = S_MUL;
          end else begin
            cmd.wr_entry = 1'b1;
          end
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_TERM;
      end
      S_TERM: begin
        cmd.term_en = 1'b1;
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        if (stat.mode_none) begin
          cmd.res_term = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          cmd.acc_en = 1'b1;
          state_nxt  = stat.last ? S_CHK : S_IDLE;
        end
      end
      S_CHK: begin
        if (stat.mode_mean && !stat.wacc_zero) begin
          cmd.chk_en = 1'b1;
          state_nxt  = S_DLOAD;
        end else begin
          cmd.res_acc = 1'b1;
          state_nxt   = S_EMIT;
        end
      end
      S_DLOAD: begin
        cmd.dload_en = 1'b1;
        cnt_nxt      = CNT_W'(NUM_W - 1);
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin_en = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        // wait for the output register to be free
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register occupancy
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/nllfr_dp.sv -----
// Datapath: config registers, weight table, multiply, accumulate, mean divider, output register.
module nllfr_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [nllfr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nllfr_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic [nllfr_pkg::SLOT_W-1:0]          in_class_slot,
  input  logic [nllfr_pkg::WGT_W-1:0]           in_weight_value,
  input  logic signed [nllfr_pkg::TGT_W-1:0]    in_target,
  input  logic signed [nllfr_pkg::X_W-1:0]      in_log_prob,
  input  logic                                  in_last,
  input  nllfr_pkg::ctrl_cmd_t                  cmd,
  output nllfr_pkg::dp_stat_t                   stat,
  output logic signed [nllfr_pkg::LOSS_W-1:0]   out_loss_value,
  output logic [nllfr_pkg::WACC_W-1:0]          out_weight_sum,
  output logic                                  out_is_final,
  output logic                                  out_range_error
);
  import nllfr_pkg::*;

  localparam logic signed [LOSS_W-1:0] LOSS_MAX = {1'b0, {(LOSS_W-1){1'b1}}};
  localparam logic signed [LOSS_W-1:0] LOSS_MIN = {1'b1, {(LOSS_W-1){1'b0}}};

  // Configuration
  logic [MODE_W-1:0]  mode_r;
  logic               use_w_r;
  logic [TGT_W-1:0]   ign_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_RST;
      use_w_r <= USEW_RST;
      ign_r   <= IGNORE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_MODE:   mode_r  <= cfg_wdata[MODE_W-1:0];
        CFG_IDX_USEW:   use_w_r <= cfg_wdata[0];
        CFG_IDX_IGNORE: ign_r   <= cfg_wdata[TGT_W-1:0];
        default: ;
      endcase
    end
  end

  // Target classification at capture; ignore takes precedence over range
  logic tgt_ign, tgt_bad;
  assign tgt_ign = (in_target == ign_r);
  assign tgt_bad = !tgt_ign &&
                   (in_target[TGT_W-1] ||
                    ({1'b0, in_target[TGT_W-2:0]} >= TGT_W'(NUM_CLASSES)));

  logic signed [X_W-1:0] x_r;
  logic                  valid_r, bad_r, last_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r     <= in_log_prob;
      valid_r <= !tgt_ign && !tgt_bad;
      bad_r   <= tgt_bad;
      last_r  <= in_last;
    end
  end

  // Class weight table
  logic [WGT_W-1:0] ram_rdata;

  nllfr_ram #(
    .WIDTH (WGT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_wtab (
    .clk   (clk),
    .we    (cmd.wr_entry),
    .waddr (in_class_slot[TABLE_AW-1:0]),
    .wdata (in_weight_value),
    .raddr (in_target[TABLE_AW-1:0]),
    .rdata (ram_rdata)
  );

  // Weighted product x*w in Q.28
  logic [WSEL_W-1:0]        w_sel, w_r;
  logic signed [PROD_W-1:0] prod_r;

  assign w_sel = use_w_r ? {1'b0, ram_rdata} : WSEL_W'(WEIGHT_ONE);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      w_r    <= w_sel;
      prod_r <= x_r * $signed({1'b0, w_sel});
    end
  end

  // Negate and round to Q.16, ties toward plus infinity
  logic signed [PROD_W:0]   neg_rnd;
  logic signed [TERM_W-1:0] term_r;

  assign neg_rnd = -$signed({prod_r[PROD_W-1], prod_r}) + (PROD_W+1)'(ROUND_HALF);

  always_ff @(posedge clk) begin
    if (cmd.term_en) begin
      term_r <= valid_r ? neg_rnd[TERM_W+FRAC_SHIFT-1:FRAC_SHIFT] : '0;
    end
  end

  // Batch accumulators with saturation
  logic signed [LOSS_W-1:0] acc_r;
  logic [WACC_W-1:0]        wacc_r;
  logic                     sticky_r;
  logic signed [LOSS_W:0]   acc_sum;
  logic [WACC_W:0]          wacc_sum;
  logic                     clr_batch;

  assign acc_sum  = $signed({{(LOSS_W+1-TERM_W){term_r[TERM_W-1]}}, term_r}) +
                    $signed({acc_r[LOSS_W-1], acc_r});
  assign wacc_sum = {1'b0, wacc_r} + (WACC_W+1)'(w_r);
  assign clr_batch = cmd.out_load && (mode_r != RED_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      wacc_r   <= '0;
      sticky_r <= 1'b0;
    end else if (clr_batch) begin
      acc_r    <= '0;
      wacc_r   <= '0;
      sticky_r <= 1'b0;
    end else if (cmd.acc_en) begin
      if (valid_r) begin
        if (acc_sum[LOSS_W] != acc_sum[LOSS_W-1]) begin
          acc_r <= acc_sum[LOSS_W] ? LOSS_MIN : LOSS_MAX;
        end else begin
          acc_r <= acc_sum[LOSS_W-1:0];
        end
        wacc_r <= wacc_sum[WACC_W] ? {WACC_W{1'b1}} : wacc_sum[WACC_W-1:0];
      end
      if (bad_r) begin
        sticky_r <= 1'b1;
      end
    end
  end

  // Mean: restoring division of (|sum| << 12 + tw/2) by tw, one bit a step
  logic              neg_r;
  logic [LOSS_W-1:0] mag_r;
  logic [NUM_W-1:0]  num_r;
  logic [WACC_W-1:0] rem_r;
  logic [WACC_W:0]   trial, trial_diff;
  logic              trial_ge;

  assign trial      = {rem_r, num_r[NUM_W-1]};
  assign trial_ge   = (trial >= {1'b0, wacc_r});
  assign trial_diff = trial - {1'b0, wacc_r};

  always_ff @(posedge clk) begin
    if (cmd.chk_en) begin
      neg_r <= acc_r[LOSS_W-1];
      mag_r <= acc_r[LOSS_W-1] ? LOSS_W'(-acc_r) : LOSS_W'(acc_r);
    end
    if (cmd.dload_en) begin
      num_r <= {mag_r, {FRAC_SHIFT{1'b0}}} + NUM_W'(wacc_r >> 1);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      num_r <= {num_r[NUM_W-2:0], trial_ge};
      rem_r <= trial_ge ? trial_diff[WACC_W-1:0] : trial[WACC_W-1:0];
    end
  end

  // Quotient saturation
  logic              q_ovf_pos, q_ovf_neg;
  logic [LOSS_W-1:0] q_neg;

  assign q_ovf_pos = |num_r[NUM_W-1:LOSS_W-1];
  assign q_ovf_neg = (|num_r[NUM_W-1:LOSS_W]) ||
                     (num_r[LOSS_W-1] && (|num_r[LOSS_W-2:0]));
  assign q_neg     = -num_r[LOSS_W-1:0];

  // Result staging
  logic signed [LOSS_W-1:0] res_r;

  always_ff @(posedge clk) begin
    if (cmd.res_term) begin
      res_r <= LOSS_W'(term_r);
    end else if (cmd.res_acc) begin
      res_r <= acc_r;
    end else if (cmd.fin_en) begin
      if (neg_r) begin
        res_r <= q_ovf_neg ? LOSS_MIN : q_neg;
      end else begin
        res_r <= q_ovf_pos ? LOSS_MAX : num_r[LOSS_W-1:0];
      end
    end
  end

  // Output register
  logic signed [LOSS_W-1:0] out_loss_r;
  logic [WACC_W-1:0]        out_tw_r;
  logic                     out_fin_r, out_rerr_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_loss_r <= res_r;
      if (mode_r == RED_NONE) begin
        out_tw_r   <= '0;
        out_fin_r  <= 1'b0;
        out_rerr_r <= bad_r;
      end else begin
        out_tw_r   <= wacc_r;
        out_fin_r  <= 1'b1;
        out_rerr_r <= sticky_r;
      end
    end
  end

  assign out_loss_value   = out_loss_r;
  assign out_weight_sum   = out_tw_r;
  assign out_is_final     = out_fin_r;
  assign out_range_error  = out_rerr_r;

  // Status to controller
  assign stat.mode_none = (mode_r == RED_NONE);
  assign stat.mode_mean = (mode_r == RED_MEAN);
  assign stat.last      = last_r;
  assign stat.wacc_zero = (wacc_r == '0);

endmodule

// ----- rtl/nll_loss_forward_reduce.sv -----
// Top level of the weighted NLL loss forward block.
//
// Input channel (in_valid/in_ready): each request either loads one entry of
// the class weight table (in_req_type 0) or carries one sample (in_req_type 1)
// with its target and the log-probability at that target.
// Result channel (out_valid/out_ready): per-sample losses in none mode, or one
// reduced loss with the total weight on the request marked last in mean/sum.
// Configuration port: cfg_we writes cfg_wdata to register cfg_index
// (0 reduction mode, 1 use weights, 2 ignore class). The user must write only
// while idle; the block itself does not enforce it. A weight load is written
// when accepted. A sample passes accept, table read and multiply, round and
// accumulate; in none mode an emit step loads the output register. A last
// sum sample, or a mean one with zero total weight, adds a check before emit;
// else the check leads to divider load, the bit-serial restoring divider (one
// quotient bit per cycle) and saturation. Past accept, in_ready stays low.
// The next request is taken while a result still waits in the output register;
// a stalled receiver only holds the block when a new result is ready to load.
// Reset clears the state machine, the accumulators and the output valid, and
// presets the configuration; the weight table is undefined until loaded.
module nll_loss_forward_reduce (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [nllfr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nllfr_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_req_type,
  input  logic [nllfr_pkg::SLOT_W-1:0]          in_class_slot,
  input  logic [nllfr_pkg::WGT_W-1:0]           in_weight_value,
  input  logic signed [nllfr_pkg::TGT_W-1:0]    in_target,
  input  logic signed [nllfr_pkg::X_W-1:0]      in_log_prob,
  input  logic                                  in_last,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [nllfr_pkg::LOSS_W-1:0]   out_loss_value,
  output logic [nllfr_pkg::WACC_W-1:0]          out_weight_sum,
  output logic                                  out_is_final,
  output logic                                  out_range_error
);
  import nllfr_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  nllfr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  nllfr_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_class_slot    (in_class_slot),
    .in_weight_value  (in_weight_value),
    .in_target        (in_target),
    .in_log_prob      (in_log_prob),
    .in_last          (in_last),
    .cmd              (cmd),
    .stat             (stat),
    .out_loss_value   (out_loss_value),
    .out_weight_sum   (out_weight_sum),
    .out_is_final     (out_is_final),
    .out_range_error  (out_range_error)
  );

endmodule

// ----- rtl/nllfr_chk.sv -----
// Port-level checker for the NLL loss forward block, bound to the top level.
module nllfr_chk (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  in_req_type,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [nllfr_pkg::LOSS_W-1:0]   out_loss_value,
  input logic [nllfr_pkg::WACC_W-1:0]          out_weight_sum,
  input logic                                  out_is_final
);
  import nllfr_pkg::*;

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_loss_value)
                               && $stable(out_weight_sum))
    else $error("result changed while stalled");

  // Per-sample results never carry a total weight
  a_tw_nonfinal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_final |-> out_weight_sum == '0)
    else $error("total weight on a per-sample result");

  // A sample request keeps the block busy for the following cycle
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == REQ_SAMPLE) |=> !in_ready)
    else $error("request taken while a sample is in flight");

  // Reset leaves no result pending
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind nll_loss_forward_reduce nllfr_chk u_nllfr_chk (.*);

// ----- bench/nll_loss_forward_reduce_test.sv -----
// Self-checking testbench for the weighted NLL loss forward block.
module nll_loss_forward_reduce_test;
  import nllfr_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int SETTLE_CYCLES = 120;   // covers a full mean divide after the last request
  localparam int RANDOM_ITEMS = 280;
  localparam int SAT_BATCH    = 100;    // a long batch of full-scale weights

  // Reduction codes the package leaves unnamed
  localparam logic [MODE_W-1:0] RED_SUM = 2'd2;
  localparam logic [MODE_W-1:0] RED_ODD = 2'd3;

  localparam longint          LOSS_MAX     = 64'sh7FFF_FFFF_FFFF;
  localparam longint          LOSS_MIN     = -64'sh8000_0000_0000;
  localparam longint unsigned LOSS_NEG_MAG = 64'h8000_0000_0000;
  localparam int unsigned     WSUM_MAX     = (1 << WACC_W) - 1;

  typedef struct {
    logic                    req_type;
    logic [SLOT_W-1:0]       slot;
    logic [WGT_W-1:0]        weight;
    logic signed [TGT_W-1:0] target;
    logic signed [X_W-1:0]   log_prob;
    logic                    last;
  } loss_request_t;

  typedef struct {
    logic signed [LOSS_W-1:0] loss;
    logic [WACC_W-1:0]        wsum;
    logic                     is_final;
    logic                     range_error;
  } loss_result_t;

  typedef enum {RS_STEADY, RS_HALF, RS_SPARSE, RS_MOSTLY} ready_style_t;

  // Predicts losses per accepted request and checks them in order
  class loss_ledger;
    logic [MODE_W-1:0]       mode;
    logic                    use_table;
    logic signed [TGT_W-1:0] ignore_tgt;
    logic [WGT_W-1:0]        class_weight [TABLE_DEPTH];
    longint                  loss_sum;
    int unsigned             weight_sum;
    bit                      batch_bad;
    loss_result_t            owed_losses [$];
    int                      failures;

    function new();
      mode       = MODE_RST;
      use_table  = USEW_RST;
      ignore_tgt = IGNORE_RST;
      loss_sum   = 0;
      weight_sum = 0;
      batch_bad  = 1'b0;
      failures   = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_IDX_MODE:   mode = val[MODE_W-1:0];
        CFG_IDX_USEW:   use_table = val[0];
        CFG_IDX_IGNORE: ignore_tgt = val;
        default: ;
      endcase
    endfunction

    function void predict_loss(loss_request_t r);
      longint          x;
      longint          term;
      longint          res;
      longint unsigned mag;
      longint unsigned quot;
      int unsigned     w;
      bit              ignored;
      bit              bad;
      loss_result_t    e;
      if (r.req_type == REQ_LOAD) begin
        class_weight[r.slot] = r.weight;
        return;
      end
      x = longint'(r.log_prob);
      ignored = (r.target == ignore_tgt);
      bad = !ignored && (r.target < 0 || r.target >= NUM_CLASSES);
      w = 0;
      term = 0;
      // -x*w in Q.28, rounded half up to Q.16
      if (!ignored && !bad) begin
        w = use_table ? 32'(class_weight[r.target[SLOT_W-1:0]]) : WEIGHT_ONE;
        term = (longint'(ROUND_HALF) - x * longint'(w)) >>> FRAC_SHIFT;
      end
      if (mode == RED_NONE) begin
        e.loss         = term[LOSS_W-1:0];
        e.wsum         = '0;
        e.is_final     = 1'b0;
        e.range_error  = bad;
        owed_losses.push_back(e);
        return;
      end
      if (!ignored && !bad) begin
        loss_sum = loss_sum + term;
        if (loss_sum > LOSS_MAX) loss_sum = LOSS_MAX;
        else if (loss_sum < LOSS_MIN) loss_sum = LOSS_MIN;
        weight_sum = weight_sum + w;
        if (weight_sum > WSUM_MAX) weight_sum = WSUM_MAX;
      end
      if (bad) batch_bad = 1'b1;
      if (!r.last) return;
      res = loss_sum;
      // mean: round to nearest, ties away from zero, then saturate
      if (mode == RED_MEAN && weight_sum != 0) begin
        mag = (loss_sum < 0) ? -loss_sum : loss_sum;
        quot = ((mag << FRAC_SHIFT) + weight_sum / 2) / weight_sum;
        if (loss_sum < 0) res = (quot > LOSS_NEG_MAG) ? LOSS_MIN : -longint'(quot);
        else res = (quot > LOSS_MAX) ? LOSS_MAX : longint'(quot);
      end
      e.loss         = res[LOSS_W-1:0];
      e.wsum         = weight_sum[WACC_W-1:0];
      e.is_final     = 1'b1;
      e.range_error  = batch_bad;
      owed_losses.push_back(e);
      loss_sum   = 0;
      weight_sum = 0;
      batch_bad  = 1'b0;
    endfunction

    function void check_loss(loss_result_t got);
      loss_result_t want;
      if (owed_losses.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("ERROR: unexpected result, loss %0d weight %0d final %0b range %0b",
                   got.loss, got.wsum, got.is_final, got.range_error);
        return;
      end
      want = owed_losses.pop_front();
      if (got.loss !== want.loss || got.wsum !== want.wsum ||
          got.is_final !== want.is_final || got.range_error !== want.range_error) begin
        failures++;
        if (failures <= 10)
          $display("ERROR: expected loss %0d weight %0d final %0b range %0b, got %0d %0d %0b %0b",
                   want.loss, want.wsum, want.is_final, want.range_error,
                   got.loss, got.wsum, got.is_final, got.range_error);
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_W-1:0]         cfg_wdata;
  logic                     in_valid;
  logic                     in_ready;
  logic                     in_req_type;
  logic [SLOT_W-1:0]        in_class_slot;
  logic [WGT_W-1:0]         in_weight_value;
  logic signed [TGT_W-1:0]  in_target;
  logic signed [X_W-1:0]    in_log_prob;
  logic                     in_last;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [LOSS_W-1:0] out_loss_value;
  logic [WACC_W-1:0]        out_weight_sum;
  logic                     out_is_final;
  logic                     out_range_error;

  loss_ledger ledger = new();

  // Stimulus-side record of which table entries hold a weight
  bit slot_loaded [TABLE_DEPTH];
  int loaded_slots [$];
  int burst_left = 0;
  bit sender_steady = 1'b0;
  int hold_request = 0;

  nll_loss_forward_reduce dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_class_slot    (in_class_slot),
    .in_weight_value  (in_weight_value),
    .in_target        (in_target),
    .in_log_prob      (in_log_prob),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_loss_value   (out_loss_value),
    .out_weight_sum   (out_weight_sum),
    .out_is_final     (out_is_final),
    .out_range_error  (out_range_error)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * 400000);
    $display("Test completed with failures");
    $finish;
  end

  function automatic loss_request_t sample_req(logic signed [TGT_W-1:0] t,
                                               logic signed [X_W-1:0] x, logic lst);
    loss_request_t r;
    r.req_type = REQ_SAMPLE;
    r.slot     = SLOT_W'($urandom);
    r.weight   = WGT_W'($urandom);
    r.target   = t;
    r.log_prob = x;
    r.last     = lst;
    return r;
  endfunction

  function automatic loss_request_t load_req(logic [SLOT_W-1:0] s, logic [WGT_W-1:0] w);
    loss_request_t r;
    r.req_type = REQ_LOAD;
    r.slot     = s;
    r.weight   = w;
    r.target   = TGT_W'($urandom);
    r.log_prob = X_W'($urandom);
    r.last     = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // Mostly valid classes; some ignored, out of range or arbitrary
  function automatic logic signed [TGT_W-1:0] draw_target();
    int sel;
    logic signed [TGT_W-1:0] t;
    sel = $urandom_range(0, 99);
    if (sel < 10) t = ledger.ignore_tgt;
    else if (sel < 22) begin
      do t = TGT_W'($urandom); while ((t >= 0 && t < NUM_CLASSES) || t == ledger.ignore_tgt);
    end else if (sel < 30) t = TGT_W'($urandom);
    else t = TGT_W'($urandom_range(0, NUM_CLASSES - 1));
    // a weighted lookup must hit a loaded entry
    if (ledger.use_table && t != ledger.ignore_tgt && t >= 0 && t < NUM_CLASSES &&
        !slot_loaded[t[SLOT_W-1:0]])
      t = TGT_W'(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]);
    return t;
  endfunction

  function automatic logic signed [X_W-1:0] draw_log_prob();
    logic signed [X_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = X_W'(-$urandom_range(0, 1 << 18));
      3, 4:    v = X_W'(-$urandom_range(0, 8388607));
      5, 6, 7: v = X_W'($urandom);
      8: begin
        case ($urandom_range(0, 4))
          0:       v = -24'sd8388608;
          1:       v = 24'sh7FFFFF;
          2:       v = '0;
          3:       v = -24'sd1;
          default: v = 24'sd1;
        endcase
      end
      default: v = X_W'($urandom_range(0, 512) - 256);
    endcase
    return v;
  endfunction

  // Offer one request in bursts with random gaps; returns in the step it is taken
  task automatic issue(input loss_request_t r);
    int gap;
    if (!sender_steady) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
        gap = $urandom_range(1, 10);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left--;
    end
    in_valid        <= 1'b1;
    in_req_type     <= r.req_type;
    in_class_slot   <= r.slot;
    in_weight_value <= r.weight;
    in_target       <= r.target;
    in_log_prob     <= r.log_prob;
    in_last         <= r.last;
    do @(posedge clk); while (!in_ready);
    ledger.predict_loss(r);
    if (r.req_type == REQ_LOAD && !slot_loaded[r.slot]) begin
      slot_loaded[r.slot] = 1'b1;
      loaded_slots.push_back(int'(r.slot));
    end
  endtask

  // Stop sending, let every owed result arrive and the block go quiet
  task automatic settle_block();
    in_valid <= 1'b0;
    while (ledger.owed_losses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    ledger.set_register(idx, val);
  endtask

  task automatic configure(input logic [MODE_W-1:0] m, input logic u,
                           input logic [CFG_W-1:0] ign);
    settle_block();
    write_reg(CFG_IDX_MODE, CFG_W'(m));
    write_reg(CFG_IDX_USEW, CFG_W'(u));
    write_reg(CFG_IDX_IGNORE, ign);
  endtask

  // Result side: check every accepted result, stall on a shifting pattern
  initial begin : result_sink
    ready_style_t style;
    int           style_left;
    int           hold_left;
    loss_result_t got;
    style = RS_STEADY;
    style_left = 0;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.loss         = out_loss_value;
        got.wsum         = out_weight_sum;
        got.is_final     = out_is_final;
        got.range_error  = out_range_error;
        ledger.check_loss(got);
      end
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (style_left == 0) begin
          style = ready_style_t'($urandom_range(0, 3));
          style_left = $urandom_range(8, 80);
        end
        style_left--;
        case (style)
          RS_STEADY: out_ready <= 1'b1;
          RS_HALF:   out_ready <= 1'($urandom_range(0, 1));
          RS_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int               issued;
    int               n_batches;
    int               blen;
    logic [MODE_W-1:0] mode_pick;
    logic [CFG_W-1:0]  ign;
    logic             last_flag;
    in_valid        <= 1'b0;
    in_req_type     <= REQ_SAMPLE;
    in_class_slot   <= '0;
    in_weight_value <= '0;
    in_target       <= '0;
    in_log_prob     <= '0;
    in_last         <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_wdata       <= '0;
    rst_n           <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Table entries used below: full scale, a half, one, the smallest, eight, zero
    issue(load_req(10'd0, 16'hFFFF));
    issue(load_req(10'd1, 16'h0800));
    issue(load_req(10'd2, 16'h1000));
    issue(load_req(10'd512, 16'h0001));
    issue(load_req(10'd1023, 16'h8000));
    issue(load_req(10'd700, 16'h0000));

    // Reset settings: mean, unit weight, default ignore value
    issue(sample_req(16'sd5, 24'sh010000, 1'b0));
    issue(sample_req(-16'sd100, 24'sd123, 1'b0));
    issue(sample_req(16'sd1023, -24'sd8388608, 1'b0));
    issue(sample_req(16'sd1024, 24'sd77, 1'b0));
    issue(sample_req(16'sd0, 24'sh7FFFFF, 1'b1));

    // Per-sample: rounding ties, extreme product, ignore at the top, zero weight
    configure(RED_NONE, 1'b1, 16'h7FFF);
    issue(sample_req(16'sd1, 24'sd1, 1'b0));
    issue(sample_req(16'sd1, -24'sd1, 1'b0));
    issue(sample_req(16'sd0, -24'sd8388608, 1'b1));
    issue(sample_req(16'sd32767, 24'sd5, 1'b0));
    issue(sample_req(-16'sd32768, 24'sd9, 1'b0));
    issue(sample_req(16'sd700, 24'sd12345, 1'b0));

    // Sum with ignore at the bottom and a range error in the batch
    configure(RED_SUM, 1'b1, 16'h8000);
    issue(sample_req(-16'sd32768, 24'sd100, 1'b0));
    issue(sample_req(16'sd2, -24'sd65536, 1'b0));
    issue(sample_req(16'sd512, 24'sd300000, 1'b0));
    issue(sample_req(16'sd32767, 24'sd1, 1'b0));
    issue(sample_req(16'sd1023, -24'sd40000, 1'b1));

    // Mean over nothing but ignored and bad targets: zero total weight
    configure(RED_MEAN, 1'b0, 16'd2);
    issue(sample_req(16'sd2, 24'sd50, 1'b0));
    issue(sample_req(-16'sd5, 24'sd60, 1'b1));

    // The spare mode code reduces as a sum
    configure(RED_ODD, 1'b0, IGNORE_RST);
    issue(sample_req(16'sd10, -24'sd65536, 1'b0));
    issue(sample_req(16'sd11, -24'sd32768, 1'b1));

    // Receiver holds off while requests keep coming, then the sender waits it out
    configure(RED_NONE, 1'b0, IGNORE_RST);
    hold_request = 300;
    sender_steady = 1'b1;
    repeat (40) issue(sample_req(draw_target(), draw_log_prob(), 1'($urandom_range(0, 1))));
    sender_steady = 1'b0;
    settle_block();
    repeat (10) issue(sample_req(draw_target(), draw_log_prob(), 1'($urandom_range(0, 1))));

    // One long batch of full-scale weights
    configure(RED_MEAN, 1'b1, IGNORE_RST);
    for (int i = 0; i < SAT_BATCH; i++)
      issue(sample_req(16'sd0, draw_log_prob(), i == SAT_BATCH - 1));

    // Random settings, each run as a few complete batches
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      mode_pick = MODE_W'($urandom_range(0, 3));
      case ($urandom_range(0, 4))
        0:       ign = IGNORE_RST;
        1:       ign = 16'h8000;
        2:       ign = 16'h7FFF;
        3:       ign = CFG_W'($urandom_range(0, NUM_CLASSES - 1));
        default: ign = CFG_W'($urandom);
      endcase
      configure(mode_pick, 1'($urandom_range(0, 1)), ign);
      n_batches = $urandom_range(2, 6);
      repeat (n_batches) begin
        blen = $urandom_range(1, 12);
        for (int i = 0; i < blen; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            issue(load_req(SLOT_W'($urandom),
                           ($urandom_range(0, 1) != 0) ? WGT_W'($urandom)
                                                       : WGT_W'($urandom_range(2048, 8192))));
            issued++;
          end
          last_flag = (i == blen - 1) || ($urandom_range(0, 24) == 0);
          issue(sample_req(draw_target(), draw_log_prob(), last_flag));
          issued++;
        end
        if ($urandom_range(0, 7) == 0) settle_block();
      end
    end

    settle_block();
    if (ledger.failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
